@@ sv/ship_pkg.sv @@
// Shared types and constants for the SHiP/SRRIP replacement engine.
`timescale 1ns / 1ps
package ship_pkg;
    localparam int SETS      = 2048;
    localparam int WAYS      = 16;
    localparam int SIG_BITS  = 14;
    localparam int RRPV_W    = 2;
    localparam int CTR_W     = 3;
    localparam int ADDR_BITS = 48;
    localparam int PC_W      = 64;
    localparam int THR_W     = 3;
    localparam int RUN_W     = 3;
    localparam int SET_W     = $clog2(SETS);
    localparam int WAY_W     = $clog2(WAYS);
    localparam int STRIDE_W  = ADDR_BITS + 1;
    localparam int SIG_COUNT = 1 << SIG_BITS;

    localparam logic [RRPV_W-1:0] RRPV_MAX = {RRPV_W{1'b1}};
    localparam logic [CTR_W-1:0]  CTR_MAX  = {CTR_W{1'b1}};
    localparam logic [CTR_W-1:0]  CTR_MID  = CTR_MAX >> 1;
    localparam logic [THR_W-1:0]  THR_RST  = THR_W'(4);

    // request kinds
    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic                reused;
        logic [SIG_BITS-1:0] sig;
        logic                valid;
        logic [RRPV_W-1:0]   rrpv;
    } t_line;

    typedef t_line [WAYS-1:0] t_row;

    localparam t_line LINE_RST = '{reused: 1'b0, sig: '0, valid: 1'b0, rrpv: RRPV_MAX};

    // per-signature stride detector entry
    typedef struct packed {
        logic [RUN_W-1:0]     run;
        logic [STRIDE_W-1:0]  stride;
        logic [ADDR_BITS-1:0] addr;
    } t_sent;

    typedef struct packed {
        t_sent entry;
        logic  stream;
    } t_stride_res;

    typedef struct packed {
        logic [WAY_W-1:0] way;
        logic             age;
        t_row             aged;
    } t_victim_res;
endpackage

@@ sv/ship_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module ship_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/ship_victim.sv @@
// Victim selection and SRRIP ageing over one set row.
`timescale 1ns / 1ps
module ship_victim (
    input  ship_pkg::t_row        i_row,
    output ship_pkg::t_victim_res o_res
);
    import ship_pkg::*;

    logic              any_inv;
    logic [WAY_W-1:0]  inv_way;
    logic [RRPV_W-1:0] top;
    logic [RRPV_W-1:0] gap;
    logic [WAY_W-1:0]  max_way;
    logic              max_found;

    always_comb begin
        any_inv   = 1'b0;
        inv_way   = '0;
        top       = '0;
        max_way   = '0;
        max_found = 1'b0;
        // first invalid way
        for (int w = 0; w < WAYS; w++) begin
            if (!i_row[w].valid && !any_inv) begin
                any_inv = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
        // largest re-reference value in the set
        for (int w = 0; w < WAYS; w++) begin
            if (i_row[w].rrpv > top) begin
                top = i_row[w].rrpv;
            end
        end
        gap = RRPV_MAX - top;
        // age every way; first way that reaches the maximum is the victim unless a way is invalid
        o_res.aged = i_row;
        for (int w = 0; w < WAYS; w++) begin
            o_res.aged[w].rrpv = i_row[w].rrpv + gap;
            if (i_row[w].rrpv == top && !max_found) begin
                max_found = 1'b1;
                max_way   = WAY_W'(w);
            end
        end
        o_res.way = any_inv ? inv_way : max_way;
        o_res.age = !any_inv;
    end
endmodule

@@ sv/ship_stride.sv @@
// Stride detector update for one signature entry.
`timescale 1ns / 1ps
module ship_stride (
    input  ship_pkg::t_sent               i_entry,
    input  logic [ship_pkg::ADDR_BITS-1:0] i_addr,
    input  logic [ship_pkg::THR_W-1:0]     i_thr,
    output ship_pkg::t_stride_res          o_res
);
    import ship_pkg::*;

    logic [STRIDE_W-1:0] stride;
    logic                match;
    logic [RUN_W:0]      run_inc;
    logic [RUN_W:0]      run_nx;

    // two's complement difference kept one bit wider than the address
    assign stride  = {1'b0, i_addr} - {1'b0, i_entry.addr};
    assign match   = (i_entry.run != '0) && (stride == i_entry.stride);
    assign run_inc = {1'b0, i_entry.run} + (RUN_W+1)'(1);

    always_comb begin
        if (match) begin
            run_nx = (run_inc > {1'b0, i_thr}) ? {1'b0, i_thr} : run_inc;
        end else begin
            run_nx = (RUN_W+1)'(1);
        end
        o_res.entry.run    = run_nx[RUN_W-1:0];
        o_res.entry.stride = stride;
        o_res.entry.addr   = i_addr;
        o_res.stream       = run_nx[RUN_W-1:0] >= i_thr;
    end
endmodule

@@ sv/ship_rrip_stride_replacement.sv @@
// Top level of the SHiP/SRRIP replacement engine with stride streaming detection.
`timescale 1ns / 1ps
// Cache replacement engine: victim requests and access updates arrive on the
// slave stream, one result item leaves on the master stream per request.
// Set rows, the stride table and the reuse counters live in three RAMs with
// registered reads. After reset a clearing pass initialises all tables; no
// item is accepted until it ends. A victim request then takes the row/stride
// read (aged row written back) and the result register; an update adds the
// evicted signature's counter read and a write-back. One item is in work at
// a time. Configuration writes are always taken.
module ship_rrip_stride_replacement (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // set_index[10:0], way[14:11], pc[78:15], address[126:79], hit[127]
    input  logic [127:0]               s_axis_tdata,
    // operation[0]
    input  logic                       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // victim_way[3:0], insert_rrpv[5:4], streaming[6], zero[7]
    output logic [7:0]                 m_axis_tdata,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ship_pkg::THR_W-1:0] i_cfg_data
);
    import ship_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CTR  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [SIG_BITS-1:0] r_clr_idx;
    logic [THR_W-1:0]    r_thr;

    logic                 r_op;
    logic [SET_W-1:0]     r_set;
    logic [WAY_W-1:0]     r_way;
    logic [SIG_BITS-1:0]  r_sig;
    logic [ADDR_BITS-1:0] r_addr;
    logic                 r_hit;
    t_row                 r_row;
    logic [SIG_BITS-1:0]  r_old_sig;
    logic                 r_train;
    logic                 r_up;
    logic [CTR_W-1:0]     r_ctr_sig;
    logic                 r_stream;
    logic [WAY_W-1:0]     r_res_way;
    logic [RRPV_W-1:0]    r_res_ins;
    logic                 r_res_stream;
    logic                 r_m_valid;
    logic [7:0]           r_m_data;

    logic                accept;
    logic [SET_W-1:0]    in_set;
    logic [SIG_BITS-1:0] in_sig;

    t_row                row_rdata, row_wdata;
    logic                row_we;
    logic [SET_W-1:0]    row_waddr;
    t_sent               sent_rdata, sent_wdata;
    logic                sent_we;
    logic [SIG_BITS-1:0] sent_waddr;
    logic [CTR_W-1:0]    ctr_rdata, ctr_wdata;
    logic                ctr_we, ctr_re;
    logic [SIG_BITS-1:0] ctr_waddr, ctr_raddr;

    t_victim_res         vic;
    t_stride_res         str;
    logic [CTR_W-1:0]    ctr_old_nx;
    logic [CTR_W-1:0]    ctr_ins;
    logic [RRPV_W-1:0]   ins;
    t_row                upd_row;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_set        = s_axis_tdata[SET_W-1:0];
    assign in_sig        = s_axis_tdata[17 +: SIG_BITS];
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // tables
    ship_ram #(.WIDTH($bits(t_row)), .DEPTH(SETS)) u_row_ram (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(row_waddr), .i_wdata(row_wdata),
        .i_re(accept), .i_raddr(in_set), .o_rdata(row_rdata)
    );

    ship_ram #(.WIDTH($bits(t_sent)), .DEPTH(SIG_COUNT)) u_stride_ram (
        .i_clk(i_clk), .i_we(sent_we), .i_waddr(sent_waddr), .i_wdata(sent_wdata),
        .i_re(accept), .i_raddr(in_sig), .o_rdata(sent_rdata)
    );

    ship_ram #(.WIDTH(CTR_W), .DEPTH(SIG_COUNT)) u_ctr_ram (
        .i_clk(i_clk), .i_we(ctr_we), .i_waddr(ctr_waddr), .i_wdata(ctr_wdata),
        .i_re(ctr_re), .i_raddr(ctr_raddr), .o_rdata(ctr_rdata)
    );

    ship_victim u_victim (.i_row(row_rdata), .o_res(vic));

    ship_stride u_stride (
        .i_entry(sent_rdata), .i_addr(r_addr), .i_thr(r_thr), .o_res(str)
    );

    // counter read: new signature on accept, evicted signature after the row read
    assign ctr_re    = accept || (r_state == S_RD);
    assign ctr_raddr = accept ? in_sig : row_rdata[r_way].sig;

    // evicted signature training, and insertion level with forwarding
    always_comb begin
        ctr_old_nx = ctr_rdata;
        if (r_up) begin
            if (ctr_rdata != CTR_MAX) begin
                ctr_old_nx = ctr_rdata + CTR_W'(1);
            end
        end else if (ctr_rdata != '0) begin
            ctr_old_nx = ctr_rdata - CTR_W'(1);
        end
        ctr_ins = (r_train && (r_old_sig == r_sig)) ? ctr_old_nx : r_ctr_sig;
        if (r_hit) begin
            ins = '0;
        end else if (r_stream) begin
            ins = RRPV_MAX;
        end else if (ctr_ins == CTR_MAX) begin
            ins = '0;
        end else if (ctr_ins > CTR_MID) begin
            ins = RRPV_MAX - RRPV_W'(1);
        end else begin
            ins = RRPV_MAX;
        end
        upd_row = r_row;
        if (r_hit) begin
            upd_row[r_way].rrpv   = '0;
            upd_row[r_way].reused = 1'b1;
        end else begin
            upd_row[r_way].valid  = 1'b1;
            upd_row[r_way].sig    = r_sig;
            upd_row[r_way].reused = 1'b0;
            upd_row[r_way].rrpv   = ins;
        end
    end

    // write ports
    always_comb begin
        row_we     = 1'b0;
        row_waddr  = r_set;
        row_wdata  = upd_row;
        sent_we    = 1'b0;
        sent_waddr = r_sig;
        sent_wdata = str.entry;
        ctr_we     = 1'b0;
        ctr_waddr  = r_old_sig;
        ctr_wdata  = ctr_old_nx;
        case (r_state)
            S_CLR: begin
                row_we     = 1'b1;
                row_waddr  = r_clr_idx[SET_W-1:0];
                row_wdata  = {WAYS{LINE_RST}};
                sent_we    = 1'b1;
                sent_waddr = r_clr_idx;
                sent_wdata = '0;
                ctr_we     = 1'b1;
                ctr_waddr  = r_clr_idx;
                ctr_wdata  = CTR_MID;
            end
            S_RD: begin
                if (r_op == OP_VICTIM) begin
                    row_we    = vic.age;
                    row_wdata = vic.aged;
                end else begin
                    sent_we = 1'b1;
                end
            end
            S_CTR: begin
                row_we = 1'b1;
                ctr_we = r_train;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_clr_idx == {SIG_BITS{1'b1}}) n_state = S_IDLE;
            S_IDLE: if (accept) n_state = S_RD;
            S_RD:   n_state = (r_op == OP_VICTIM) ? S_OUT : S_CTR;
            S_CTR:  n_state = S_OUT;
            S_OUT:  if (!r_m_valid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_idx <= '0;
            r_thr     <= THR_RST;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_idx <= r_clr_idx + SIG_BITS'(1);
            end
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (r_state == S_OUT && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= s_axis_tuser;
            r_set  <= in_set;
            r_way  <= s_axis_tdata[11 +: WAY_W];
            r_sig  <= in_sig;
            r_addr <= s_axis_tdata[79 +: ADDR_BITS];
            r_hit  <= s_axis_tdata[127];
        end
        if (r_state == S_RD) begin
            r_row     <= row_rdata;
            r_old_sig <= row_rdata[r_way].sig;
            r_train   <= !r_hit && row_rdata[r_way].valid;
            r_up      <= row_rdata[r_way].reused;
            r_ctr_sig <= ctr_rdata;
            r_stream  <= str.stream;
            if (r_op == OP_VICTIM) begin
                r_res_way    <= vic.way;
                r_res_ins    <= '0;
                r_res_stream <= 1'b0;
            end
        end
        if (r_state == S_CTR) begin
            r_res_way    <= '0;
            r_res_ins    <= ins;
            r_res_stream <= r_stream;
        end
        if (r_state == S_OUT && (!r_m_valid || m_axis_tready)) begin
            r_m_data <= {1'b0, r_res_stream, r_res_ins, r_res_way};
        end
    end
endmodule
